/* rtl/tilt_angle_from_duty_cycle_macros.svh */
// Assertion macros for the tilt angle block.
// Used by the top level only; no other dependencies.
`ifndef TILT_ANGLE_FROM_DUTY_CYCLE_MACROS_SVH
`define TILT_ANGLE_FROM_DUTY_CYCLE_MACROS_SVH

// Property that holds on every rising clock edge outside reset.
`define TAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tad_pkg.sv */
// Package for the tilt angle block: widths, constants, arctangent table.
// No dependencies; used by every module of the block.
package tad_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned NumSteps = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;

  // Angle accumulator in Q.16 degrees; x/y in Q4.12 scaled by 256, with growth.
  localparam int unsigned ZW = 26;
  localparam int unsigned VW = 28;
  localparam int unsigned DivW = 16;

  typedef enum logic [2:0] {
    RegOffsetX  = 3'd0,
    RegOffsetY  = 3'd1,
    RegGainX    = 3'd2,
    RegGainY    = 3'd3,
    RegTempCoef = 3'd4,
    RegTempRef  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] temp_coeff;
    logic [7:0]  temp_ref;
  } cfg_t;

  // Arctangent of 2^-i in Q.16 degrees.
  function automatic logic [ZW-1:0] atan_lut(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0: r = 26'd2949120;  1: r = 26'd1740967;  2: r = 26'd919879;  3: r = 26'd466945;
      4: r = 26'd234379;   5: r = 26'd117304;   6: r = 26'd58666;   7: r = 26'd29335;
      8: r = 26'd14668;    9: r = 26'd7334;     10: r = 26'd3667;   11: r = 26'd1833;
      12: r = 26'd917;     13: r = 26'd458;     14: r = 26'd229;    15: r = 26'd115;
      16: r = 26'd57;      17: r = 26'd29;      18: r = 26'd14;     19: r = 26'd7;
      20: r = 26'd4;       21: r = 26'd2;       22: r = 26'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tad_if.sv */
// Valid/ready channel interface carrying a generic payload word.
// Depends on nothing; payload type set per instance.
interface tad_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tilt_angle_from_duty_cycle.sv */
// An accepted word passes through the divider, the axis stages, the CORDIC and the
// output stages to the result word. Throughput: one word per cycle; the whole pipeline
// advances whenever the output register is empty or being taken.
// Reset: control valid bits clear asynchronously; registers take their
// documented defaults. Payload registers are not reset.
`include "tilt_angle_from_duty_cycle_macros.svh"
module tilt_angle_from_duty_cycle import tad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tad_if.sink         in_if,
  tad_if.source       out_if
);
  localparam int unsigned Lat = DivW + 1 + 2 + NumSteps + 1 + 3;

  // Configuration registers.
  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd30406, 16'd31564, 16'd31284, 16'd32828, 16'd577, 8'd160};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegOffsetX:  cfg_q.offset_x <= cfg_data_i;
        RegOffsetY:  cfg_q.offset_y <= cfg_data_i;
        RegGainX:    cfg_q.gain_x <= cfg_data_i;
        RegGainY:    cfg_q.gain_y <= cfg_data_i;
        RegTempCoef: cfg_q.temp_coeff <= cfg_data_i;
        RegTempRef:  cfg_q.temp_ref <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Global stall: advance when the output slot is free or being drained.
  logic en;
  logic [Lat-1:0] vld_q;
  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_if.valid};
  end

  // Side data that rides alongside the divider.
  localparam int unsigned DL = DivW + 1;
  logic       bad_q [DL];
  logic [7:0] tk_q  [DL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_q[0] <= in_if.data.period_x == '0 || in_if.data.period_y == '0;
      tk_q[0]  <= in_if.data.temp_ticks;
      for (int k = 1; k < DL; k++) begin
        bad_q[k] <= bad_q[k-1];
        tk_q[k]  <= tk_q[k-1];
      end
    end
  end

  logic [15:0] rx, ry;
  tad_div u_div_x (.clk_i, .en_i(en), .high_i(in_if.data.high_x),
                   .period_i(in_if.data.period_x), .ratio_o(rx));
  tad_div u_div_y (.clk_i, .en_i(en), .high_i(in_if.data.high_y),
                   .period_i(in_if.data.period_y), .ratio_o(ry));

  // Axis stage 1: signed difference and magnitude product.
  logic        sx_q, sy_q, b1_q;
  logic [7:0]  t1_q;
  logic [31:0] px_q, py_q;
  logic signed [16:0] dx, dy;
  assign dx = signed'({1'b0, rx}) - signed'({1'b0, cfg_q.offset_x});
  assign dy = signed'({1'b0, ry}) - signed'({1'b0, cfg_q.offset_y});
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= dx[16];
      sy_q <= dy[16];
      px_q <= (dx[16] ? 16'(-dx) : dx[15:0]) * cfg_q.gain_x;
      py_q <= (dy[16] ? 16'(-dy) : dy[15:0]) * cfg_q.gain_y;
      b1_q <= bad_q[DL-1];
      t1_q <= tk_q[DL-1];
    end
  end

  // Axis stage 2: shift, saturate, apply sign.
  logic signed [15:0] ax_q, ay_q;
  logic [14:0] mx, my;
  logic        b2_q;
  logic [7:0]  t2_q;
  assign mx = (px_q[31:16] > 16'd32767) ? 15'h7FFF : px_q[30:16];
  assign my = (py_q[31:16] > 16'd32767) ? 15'h7FFF : py_q[30:16];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= sx_q ? -signed'({1'b0, mx}) : signed'({1'b0, mx});
      ay_q <= sy_q ? -signed'({1'b0, my}) : signed'({1'b0, my});
      b2_q <= b1_q || (mx == '0 && my == '0);
      t2_q <= t1_q;
    end
  end

  logic signed [ZW-1:0] z;
  tad_cordic u_cordic (.clk_i, .en_i(en), .num_i(ax_q), .den_i(ay_q), .z_o(z));

  localparam int unsigned CL = NumSteps + 1;
  logic       bc_q [CL];
  logic [7:0] tc_q [CL];
  always_ff @(posedge clk_i) begin
    if (en) begin
      bc_q[0] <= b2_q;
      tc_q[0] <= t2_q;
      for (int k = 1; k < CL; k++) begin
        bc_q[k] <= bc_q[k-1];
        tc_q[k] <= tc_q[k-1];
      end
    end
  end

  // Output stage 1: round to Q.8, fold, rotate; temperature product.
  logic signed [18:0] zr, zf, zrot;
  logic signed [18:0] ang_q;
  logic signed [25:0] tcor_q;
  logic        b3_q;
  assign zr = 19'((z + ZW'(128)) >>> 8);
  always_comb begin
    zf = zr;
    if (zr <= -19'sd46080) zf = zr + 19'sd92160;
    else if (zr > 19'sd46080) zf = zr - 19'sd92160;
    if (zf > -19'sd46080 && zf <= 19'sd23040) zrot = zf + 19'sd23040;
    else zrot = zf - 19'sd69120;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q  <= zrot;
      tcor_q <= signed'({1'b0, cfg_q.temp_coeff}) *
                (signed'({1'b0, cfg_q.temp_ref}) - signed'({1'b0, tc_q[CL-1]}));
      b3_q   <= bc_q[CL-1];
    end
  end

  // Output stage 2: exact sum in Q.12.
  logic signed [27:0] v_q;
  logic        b4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q  <= (28'(ang_q) <<< 4) + 28'(tcor_q) + 28'sd2048;
      b4_q <= b3_q;
    end
  end

  // Output stage 3: truncate toward zero, saturate, sign-magnitude.
  logic [27:0] av;
  logic [15:0] mg;
  assign av = v_q[27] ? 28'(-v_q) : v_q;
  assign mg = (av[27:12] > 16'd32767) ? 16'd32767 : av[27:12];
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (b4_q) begin
        out_if.data.angle_code    <= '0;
        out_if.data.input_invalid <= 1'b1;
      end else begin
        out_if.data.angle_code    <= {v_q[27] && mg != '0, mg[14:0]};
        out_if.data.input_invalid <= 1'b0;
      end
    end
  end

  assign out_if.valid = vld_q[Lat-1];

  // A presented result word that carries the invalid flag.
  logic out_inv;
  assign out_inv = out_if.valid && out_if.data.input_invalid;

  `TAD_ASSERT(a_ready_when_free, !out_if.valid |-> in_if.ready, "ready low with free output")
  `TAD_ASSERT_NEXT(a_hold_stall, out_if.valid && !out_if.ready, $stable(vld_q), "moved in stall")
  `TAD_ASSERT(a_invalid_zero, out_inv |-> out_if.data.angle_code == '0, "invalid with angle")
endmodule

/* rtl/tad_div.sv */
// Pipelined restoring divider: floor(high * 65536 / period), saturated.
// Uses tad_pkg; one quotient bit per stage, 16 stages plus a saturation stage.
module tad_div import tad_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] high_i,
  input  logic [15:0] period_i,
  output logic [15:0] ratio_o
);
  // Integer part of high/period decides saturation; fraction bits come serially.
  logic [DivW-1:0] rem_q [DivW+1];
  logic [DivW-1:0] quo_q [DivW+1];
  logic [DivW-1:0] den_q [DivW+1];
  logic            sat_q [DivW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (period_i == '0 || high_i >= period_i) begin
        rem_q[0] <= '0;
      end else begin
        rem_q[0] <= high_i;
      end
      sat_q[0] <= (period_i != '0) && (high_i >= period_i);
      quo_q[0] <= '0;
      den_q[0] <= period_i;
    end
  end

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [DivW:0] trial;
    assign trial = {rem_q[s], 1'b0} - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[DivW]) begin
          rem_q[s+1] <= trial[DivW-1:0];
          quo_q[s+1] <= {quo_q[s][DivW-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= {rem_q[s][DivW-2:0], 1'b0};
          quo_q[s+1] <= {quo_q[s][DivW-2:0], 1'b0};
        end
        den_q[s+1] <= den_q[s];
        sat_q[s+1] <= sat_q[s];
      end
    end
  end

  assign ratio_o = sat_q[DivW] ? 16'hFFFF : quo_q[DivW];
endmodule

/* rtl/tad_cordic.sv */
// Pipelined vectoring CORDIC for atan2(num, den) in Q.16 degrees.
// Uses tad_pkg; a pre-rotation register stage, then one micro-rotation per register stage.
module tad_cordic import tad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [15:0]   num_i,
  input  logic signed [15:0]   den_i,
  output logic signed [ZW-1:0] z_o
);
  logic signed [VW-1:0] x_q [NumSteps+1];
  logic signed [VW-1:0] y_q [NumSteps+1];
  logic signed [ZW-1:0] z_q [NumSteps+1];

  // Pre-rotation by +-90 degrees into the right half plane.
  logic signed [VW-1:0] xi, yi;
  assign xi = VW'(den_i) <<< 8;
  assign yi = VW'(num_i) <<< 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (xi < 0) begin
        if (yi >= 0) begin
          x_q[0] <= yi;
          y_q[0] <= -xi;
          z_q[0] <= ZW'(signed'(2949120 * 2));
        end else begin
          x_q[0] <= -yi;
          y_q[0] <= xi;
          z_q[0] <= -ZW'(signed'(2949120 * 2));
        end
      end else begin
        x_q[0] <= xi;
        y_q[0] <= yi;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NumSteps; i++) begin : g_rot
    logic signed [VW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + signed'(atan_lut(i));
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - signed'(atan_lut(i));
        end
      end
    end
  end

  assign z_o = z_q[NumSteps];
endmodule

/* test/tb_top.sv */
// Self-checking testbench for the tilt angle block: random and directed measurement words.
// Depends on tad_pkg, the tad_if channel interface and the tilt_angle_from_duty_cycle top level.
`timescale 1ns / 100ps
module tb_top import tad_pkg::*; ();

  typedef struct packed {
    logic [15:0] high_x;
    logic [15:0] period_x;
    logic [15:0] high_y;
    logic [15:0] period_y;
    logic [7:0]  temp_ticks;
  } meas_word_t;

  typedef struct packed {
    logic [15:0] angle_code;
    logic        input_invalid;
  } angle_word_t;

  localparam int unsigned Latency = 39;
  localparam int unsigned StallLimit = 5000;
  localparam longint AtanQ16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  tad_if #(.payload_t(meas_word_t))  in_ch ();
  tad_if #(.payload_t(angle_word_t)) out_ch ();

  tilt_angle_from_duty_cycle uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration registers.
  logic [15:0] sh_offset_x, sh_offset_y, sh_gain_x, sh_gain_y, sh_coeff;
  logic [7:0]  sh_ref;

  meas_word_t  pending_meas[$];
  angle_word_t expected_angles[$];
  int unsigned errors = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned invalid_seen = 0;
  int unsigned stall_cycles = 0;
  bit          word_taken = 1'b0;
  bit          no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 13) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint duty_q16(logic [15:0] high, logic [15:0] period);
    longint r;
    r = (longint'(high) << 16) / longint'(period);
    return (r > 65535) ? 65535 : r;
  endfunction

  function automatic longint axis_q12(longint ratio, logic [15:0] offset, logic [15:0] gain);
    longint d, mag;
    d = ratio - longint'(offset);
    mag = ((d < 0 ? -d : d) * longint'(gain)) >>> 16;
    if (mag > 32767) mag = 32767;
    return (d < 0) ? -mag : mag;
  endfunction

  // Vectoring CORDIC: atan2(num, den) in Q.8 degrees folded into (-180, 180].
  function automatic longint atan2_q8(longint num, longint den);
    longint x, y, z, t, xs, ys;
    x = den * 256;
    y = num * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < NumSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += AtanQ16[i];
      end else begin
        x = x - ys; y = y + xs; z -= AtanQ16[i];
      end
    end
    z = (z + 128) >>> 8;
    if (z <= -180 * 256) z += 360 * 256;
    if (z > 180 * 256) z -= 360 * 256;
    return z;
  endfunction

  function automatic angle_word_t tilt_predict(meas_word_t w);
    angle_word_t res;
    longint ax, ay, ang, v, whole, mag;
    res.angle_code = '0;
    res.input_invalid = 1'b1;
    if (w.period_x == 0 || w.period_y == 0) return res;
    ax = axis_q12(duty_q16(w.high_x, w.period_x), sh_offset_x, sh_gain_x);
    ay = axis_q12(duty_q16(w.high_y, w.period_y), sh_offset_y, sh_gain_y);
    if (ax == 0 && ay == 0) return res;
    ang = atan2_q8(ax, ay);
    if (ang > -180 * 256 && ang <= 90 * 256) ang += 90 * 256;
    else ang -= 270 * 256;
    v = ang * 16 + longint'(sh_coeff) * (longint'(sh_ref) - longint'(w.temp_ticks)) + 2048;
    whole = (v >= 0) ? (v >>> 12) : -((-v) >>> 12);
    mag = (whole < 0) ? -whole : whole;
    if (mag > 32767) mag = 32767;
    res.angle_code = mag[15:0];
    if (whole < 0) res.angle_code[15] = 1'b1;
    res.input_invalid = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", words_out, field, got, want);
  endtask

  // Register write, issued and withdrawn at falling edges; also updates the shadow copy.
  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      RegOffsetX:  sh_offset_x = value;
      RegOffsetY:  sh_offset_y = value;
      RegGainX:    sh_gain_x = value;
      RegGainY:    sh_gain_y = value;
      RegTempCoef: sh_coeff = value;
      RegTempRef:  sh_ref = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] ox, logic [15:0] oy, logic [15:0] gx,
                           logic [15:0] gy, logic [15:0] tc, logic [7:0] tr);
    write_reg(RegOffsetX, ox);
    write_reg(RegOffsetY, oy);
    write_reg(RegGainX, gx);
    write_reg(RegGainY, gy);
    write_reg(RegTempCoef, tc);
    write_reg(RegTempRef, {8'h00, tr});
  endtask

  function automatic meas_word_t make_meas(logic [15:0] hx, logic [15:0] px, logic [15:0] hy,
                                           logic [15:0] py, logic [7:0] tk);
    meas_word_t w;
    w.high_x = hx; w.period_x = px; w.high_y = hy; w.period_y = py; w.temp_ticks = tk;
    return w;
  endfunction

  // Mostly plausible duty cycles between zero and full scale; some raw noise.
  function automatic meas_word_t random_meas();
    meas_word_t w;
    if ($urandom_range(0, 9) < 3) begin
      w = 72'({$urandom, $urandom, $urandom});
      if ($urandom_range(0, 15) == 0) w.period_x = '0;
      if ($urandom_range(0, 15) == 0) w.period_y = '0;
    end else begin
      w.period_x = 16'($urandom_range(100, 65535));
      w.period_y = 16'($urandom_range(100, 65535));
      w.high_x = 16'($urandom_range(0, w.period_x));
      w.high_y = 16'($urandom_range(0, w.period_y));
      w.temp_ticks = 8'($urandom);
    end
    return w;
  endfunction

  task automatic drain_phase();
    wait (pending_meas.size() == 0 && expected_angles.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  // Input driver: a new word goes out once the last was taken and any idle gap is over.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (word_taken || !in_ch.valid) begin
      word_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_meas.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_meas.pop_front();
        send_gap = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  // Accepted input words are predicted; accepted results are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_angles.push_back(tilt_predict(in_ch.data));
        word_taken = 1'b1;
        words_in++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_angles.size() == 0) begin
          errors++;
          $display("result word with nothing outstanding");
        end else begin
          angle_word_t want;
          want = expected_angles.pop_front();
          if (out_ch.data.angle_code !== want.angle_code)
            report_mismatch("angle_code", out_ch.data.angle_code, want.angle_code);
          if (out_ch.data.input_invalid !== want.input_invalid)
            report_mismatch("input_invalid", out_ch.data.input_invalid, want.input_invalid);
          if (want.input_invalid) invalid_seen++;
        end
        words_out++;
      end
      // Watchdog on traffic that stops moving.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (pending_meas.size() == 0 && expected_angles.size() == 0)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("no progress for %0d cycles", StallLimit);
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    sh_offset_x = 16'd30406; sh_offset_y = 16'd31564;
    sh_gain_x = 16'd31284; sh_gain_y = 16'd32828;
    sh_coeff = 16'd577; sh_ref = 8'd160;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults with directed corner cases.
    pending_meas.push_back(make_meas(16'd100, 16'd0, 16'd100, 16'd200, 8'd0));
    pending_meas.push_back(make_meas(16'd100, 16'd200, 16'd100, 16'd0, 8'd255));
    pending_meas.push_back(make_meas(16'd0, 16'd0, 16'd0, 16'd0, 8'd0));
    pending_meas.push_back(make_meas(16'hffff, 16'd1, 16'hffff, 16'd1, 8'd255));
    pending_meas.push_back(make_meas(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'd160));
    pending_meas.push_back(make_meas(16'd0, 16'hffff, 16'd0, 16'hffff, 8'd0));
    pending_meas.push_back(make_meas(16'd0, 16'd1, 16'hffff, 16'd1, 8'd160));
    pending_meas.push_back(make_meas(16'hffff, 16'd1, 16'd0, 16'd1, 8'd160));
    pending_meas.push_back(make_meas(16'd900, 16'd1000, 16'd10, 16'd20, 8'd255));
    pending_meas.push_back(make_meas(16'd100, 16'd1000, 16'd900, 16'd1000, 8'd0));
    pending_meas.push_back(make_meas(16'd5000, 16'd1000, 16'd5000, 16'd1000, 8'd10));
    pending_meas.push_back(make_meas(16'd464, 16'd1000, 16'd100, 16'd1000, 8'd200));
    pending_meas.push_back(make_meas(16'd464, 16'd1000, 16'd900, 16'd1000, 8'd100));
    drain_phase();

    // Six register settings, extremes included; one run with no idling.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16'd30406, 16'd31564, 16'd31284, 16'd32828, 16'd577, 8'd160);
        1: write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        2: write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
        3: write_all(16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'h0000, 8'h00);
        default: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 8'($urandom));
      endcase
      no_idle = (ph == 4);
      if (ph == 1) pending_meas.push_back(make_meas(16'd50, 16'd100, 16'd50, 16'd100, 8'd0));
      for (int n = 0; n < 80; n++) pending_meas.push_back(random_meas());
      drain_phase();
    end

    $display("%0d measurement words sent, %0d results checked, %0d flagged invalid",
             words_in, words_out, invalid_seen);
    $display("covered reset, zero, full-scale and random register settings");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
